/* sv/jmcf_pkg.sv */
// Shared types and constants of the jump mat contact and flight timer.
// Holds the register map, the result kinds and the result record.
// Depends on nothing; every other file of the block but jmcf_in_if imports it.
package jmcf_pkg;

    localparam int TIME_BITS_DEF = 24;
    localparam int OUT_TIME_W    = 24;
    localparam int JUMP_CNT_W    = 16;
    localparam int SER_CNT_W     = 8;
    localparam int KIND_W        = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;
    localparam int RQ_DEPTH      = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FLIGHT_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIGHT_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMPS_SERIES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES_TOTAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_TICKS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ON_MAT = 3'd6;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_VALID      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TOO_SHORT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CYCLE_LONG = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REST_OVER  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END        = 3'd5;

    typedef struct packed {
        logic [15:0]           flight_min;
        logic [15:0]           flight_max;
        logic [23:0]           cycle_max;
        logic [SER_CNT_W-1:0]  jumps_per_series;
        logic [SER_CNT_W-1:0]  series_total;
        logic [23:0]           rest_ticks;
        logic                  start_on_mat;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [OUT_TIME_W-1:0] flight_ticks;
        logic [OUT_TIME_W-1:0] contact_ticks;
        logic [JUMP_CNT_W-1:0] jump_number;
        logic [SER_CNT_W-1:0]  series_number;
        logic                  end_cause;
        logic                  ready_lamp;
        logic                  last;
    } t_result;

    // Results produced by one tick: a count of zero to two and the records.
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_core_out;

endpackage

/* sv/jmcf_in_if.sv */
// Input channel of the jump mat timer: one beat is one timer tick.
// Depends on nothing.
interface jmcf_in_if;
    logic valid;
    logic ready;
    logic on_mat;
    logic stop_key;
    logic start_test;

    modport source (output valid, output on_mat, output stop_key, output start_test,
                    input ready);
    modport sink (input valid, input on_mat, input stop_key, input start_test,
                  output ready);
endinterface

/* sv/jmcf_out_if.sv */
// Result channel of the jump mat timer: one beat is one result record.
// Depends on jmcf_pkg for the field widths.
interface jmcf_out_if import jmcf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [OUT_TIME_W-1:0] flight_ticks;
    logic [OUT_TIME_W-1:0] contact_ticks;
    logic [JUMP_CNT_W-1:0] jump_number;
    logic [SER_CNT_W-1:0]  series_number;
    logic                  end_cause;
    logic                  ready_lamp;
    logic                  last;

    modport source (output valid, output kind, output flight_ticks, output contact_ticks,
                    output jump_number, output series_number, output end_cause,
                    output ready_lamp, output last, input ready);
    modport sink (input valid, input kind, input flight_ticks, input contact_ticks,
                  input jump_number, input series_number, input end_cause,
                  input ready_lamp, input last, output ready);
endinterface

/* sv/jmcf_core.sv */
// Timing state and per-tick judgement of the jump mat timer.
// Depends on jmcf_pkg; produces up to two result records per accepted tick.
module jmcf_core import jmcf_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_accept,
    input  logic      i_on_mat,
    input  logic      i_stop_key,
    input  logic      i_start_test,
    output t_core_out o_res
);

    localparam int CW = (TIME_BITS + 1 > 25) ? TIME_BITS + 1 : 25;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_CONTACT = 3'd1;
    localparam logic [2:0] PH_FLIGHT  = 3'd2;
    localparam logic [2:0] PH_REST    = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    logic [2:0]            r_phase, n_phase;
    logic [TIME_BITS-1:0]  r_tick, n_tick;
    logic [TIME_BITS-1:0]  r_ref, n_ref;
    logic [TIME_BITS-1:0]  r_contact, n_contact;
    logic [SER_CNT_W-1:0]  r_jis, n_jis;
    logic [SER_CNT_W-1:0]  r_sdone, n_sdone;
    logic [JUMP_CNT_W-1:0] r_vj, n_vj;
    logic                  r_lamp, n_lamp;

    logic [TIME_BITS-1:0]  now, elapsed;
    logic                  have0, end_now, end_cause;
    logic [KIND_W-1:0]     kind0;
    t_result               rec0, rec_end;

    always_comb begin
        // A start bit clears everything before this tick is judged.
        n_phase   = i_start_test ? PH_IDLE : r_phase;
        now       = i_start_test ? '0 : r_tick;
        n_ref     = i_start_test ? '0 : r_ref;
        n_contact = i_start_test ? '0 : r_contact;
        n_jis     = i_start_test ? '0 : r_jis;
        n_sdone   = i_start_test ? '0 : r_sdone;
        n_vj      = i_start_test ? '0 : r_vj;
        n_lamp    = i_start_test ? 1'b1 : r_lamp;
        n_tick    = now + TIME_BITS'(1);
        elapsed   = now - n_ref;
        have0     = 1'b0;
        kind0     = KIND_VALID;
        end_now   = 1'b0;
        end_cause = 1'b0;
        rec0      = '0;
        rec_end   = '0;

        case (n_phase)
            PH_IDLE: begin
                if (i_on_mat) begin
                    n_ref   = i_cfg.start_on_mat ? '0 : now;
                    n_phase = PH_CONTACT;
                end
            end
            PH_CONTACT: begin
                if (!i_on_mat) begin
                    n_contact = elapsed;
                    n_ref     = now;
                    n_phase   = PH_FLIGHT;
                end
            end
            PH_FLIGHT: begin
                if (i_on_mat) begin
                    n_ref   = now;
                    n_phase = PH_CONTACT;
                    have0   = 1'b1;
                    if (CW'(elapsed) < CW'(i_cfg.flight_min)) begin
                        kind0 = KIND_TOO_SHORT;
                    end else if (CW'(elapsed) > CW'(i_cfg.flight_max)) begin
                        kind0 = KIND_TOO_LONG;
                    end else if (CW'(elapsed) + CW'(n_contact) > CW'(i_cfg.cycle_max)) begin
                        kind0 = KIND_CYCLE_LONG;
                    end else begin
                        kind0 = KIND_VALID;
                        n_vj  = n_vj + JUMP_CNT_W'(1);
                        n_jis = n_jis + SER_CNT_W'(1);
                        if (n_jis >= i_cfg.jumps_per_series) begin
                            n_sdone = n_sdone + SER_CNT_W'(1);
                            n_phase = PH_REST;
                            n_lamp  = 1'b0;
                        end
                    end
                    rec0.flight_ticks  = OUT_TIME_W'(elapsed);
                    rec0.contact_ticks = OUT_TIME_W'(n_contact);
                end
            end
            PH_REST: begin
                if (CW'(elapsed) >= CW'(i_cfg.rest_ticks)) begin
                    n_lamp  = 1'b1;
                    n_jis   = '0;
                    n_phase = PH_CONTACT;
                    have0   = 1'b1;
                    kind0   = KIND_REST_OVER;
                end
            end
            default: begin
            end
        endcase

        rec0.kind          = kind0;
        rec0.jump_number   = n_vj;
        rec0.series_number = n_sdone;
        rec0.ready_lamp    = n_lamp;

        if (n_phase != PH_DONE) begin
            if (i_stop_key) begin
                end_now = 1'b1;
            end else if (n_sdone >= i_cfg.series_total) begin
                end_now   = 1'b1;
                end_cause = 1'b1;
            end
        end
        if (end_now) begin
            n_phase = PH_DONE;
            n_lamp  = 1'b1;
        end

        rec_end.kind          = KIND_END;
        rec_end.jump_number   = n_vj;
        rec_end.series_number = n_sdone;
        rec_end.end_cause     = end_cause;
        rec_end.ready_lamp    = 1'b1;
        rec_end.last          = 1'b1;
        rec0.last             = !end_now;

        o_res.n  = i_accept ? (2'(have0) + 2'(end_now)) : 2'd0;
        o_res.r0 = have0 ? rec0 : rec_end;
        o_res.r1 = rec_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_ref     <= '0;
            r_contact <= '0;
            r_jis     <= '0;
            r_sdone   <= '0;
            r_vj      <= '0;
            r_lamp    <= 1'b1;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_ref     <= n_ref;
            r_contact <= n_contact;
            r_jis     <= n_jis;
            r_sdone   <= n_sdone;
            r_vj      <= n_vj;
            r_lamp    <= n_lamp;
        end
    end

    // The lamp is dark exactly while the block rests between series.
    a_lamp_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_REST) == !r_lamp)
        else $error("lamp level disagrees with rest phase");

    // A finished test stays silent unless a new test is started.
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !i_start_test) |-> (o_res.n == 2'd0))
        else $error("result produced after test end");

    // Two results in one tick always close with the end record.
    a_pair_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.n == 2'd2) |-> (o_res.r1.kind == KIND_END && o_res.r0.kind != KIND_END))
        else $error("bad result pair");

endmodule

/* sv/jmcf_result_q.sv */
// Small result queue of the jump mat timer: takes up to two records per
// cycle and hands out one per beat. Depends on jmcf_pkg.
module jmcf_result_q import jmcf_pkg::*; #(
    parameter int DEPTH = RQ_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result i_d0,
    input  t_result i_d1,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_pop_ready,
    output t_result o_data
);

    localparam int AW = $clog2(DEPTH);

    t_result          r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [AW:0]      r_count, n_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_pop_ready;
    assign o_space = (r_count <= (AW+1)'(DEPTH - 2));
    assign o_data  = r_mem[r_rptr];
    assign n_count = r_count + (AW+1)'(i_push_n) - (AW+1)'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wptr] <= i_d0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wptr + AW'(1)] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + AW'(i_push_n);
            r_rptr  <= r_rptr + AW'(pop);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> o_space)
        else $error("push into a full result queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("result queue count out of range");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |=> o_valid)
        else $error("pushed record not offered");

endmodule

/* sv/jump_mat_contact_flight_timer_unit.sv */
// Top level of the jump mat contact and flight timer.
// Depends on jmcf_pkg, jmcf_in_if, jmcf_out_if, jmcf_core and jmcf_result_q.
//
// Usage:
// Each beat on the input channel is one timer tick carrying the mat level, the
// stop key and the start bit. The block counts ticks itself, times contact and
// flight phases, judges each flight on its landing tick, handles the rest
// between series and signals the end of the test. A tick yields zero, one or
// two result beats; the final beat of a tick has last set.
// Results of a tick are registered in the result queue and offered from there.
// Throughput: one tick per cycle while the receiver keeps up; a tick with two
// results needs two output beats. The four-entry result queue sets this: the
// input is ready whenever at least two entries are free, so ticks keep
// flowing while earlier results wait to be taken.
// When the receiver stalls, results stay in the queue and the input stops
// once the queue cannot hold a full tick's worth of results.
// Reset clears the timing state and loads the register defaults; a test is
// already running after reset. Registers are written through the plain write
// port and should change only while no results are pending.
module jump_mat_contact_flight_timer_unit import jmcf_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    jmcf_in_if.sink               i_beat,
    jmcf_out_if.source            o_result
);

    t_cfg      r_cfg;
    t_core_out core_res;
    t_result   q_data;
    logic      q_space;
    logic      accept;

    // Register file: a write to an index beyond the map is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flight_min       <= 16'd0;
            r_cfg.flight_max       <= 16'hFFFF;
            r_cfg.cycle_max        <= 24'hFFFFFF;
            r_cfg.jumps_per_series <= 8'd1;
            r_cfg.series_total     <= 8'd1;
            r_cfg.rest_ticks       <= 24'd0;
            r_cfg.start_on_mat     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FLIGHT_MIN:   r_cfg.flight_min       <= i_cfg_data[15:0];
                CFG_FLIGHT_MAX:   r_cfg.flight_max       <= i_cfg_data[15:0];
                CFG_CYCLE_MAX:    r_cfg.cycle_max        <= i_cfg_data[23:0];
                CFG_JUMPS_SERIES: r_cfg.jumps_per_series <= i_cfg_data[7:0];
                CFG_SERIES_TOTAL: r_cfg.series_total     <= i_cfg_data[7:0];
                CFG_REST_TICKS:   r_cfg.rest_ticks       <= i_cfg_data[23:0];
                CFG_START_ON_MAT: r_cfg.start_on_mat     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A tick is taken whenever the queue can absorb the worst case of two results.
    assign i_beat.ready = q_space;
    assign accept       = i_beat.valid && q_space;

    jmcf_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_on_mat     (i_beat.on_mat),
        .i_stop_key   (i_beat.stop_key),
        .i_start_test (i_beat.start_test),
        .o_res        (core_res)
    );

    jmcf_result_q #(
        .DEPTH (RQ_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (core_res.n),
        .i_d0        (core_res.r0),
        .i_d1        (core_res.r1),
        .o_space     (q_space),
        .o_valid     (o_result.valid),
        .i_pop_ready (o_result.ready),
        .o_data      (q_data)
    );

    assign o_result.kind          = q_data.kind;
    assign o_result.flight_ticks  = q_data.flight_ticks;
    assign o_result.contact_ticks = q_data.contact_ticks;
    assign o_result.jump_number   = q_data.jump_number;
    assign o_result.series_number = q_data.series_number;
    assign o_result.end_cause     = q_data.end_cause;
    assign o_result.ready_lamp    = q_data.ready_lamp;
    assign o_result.last          = q_data.last;

endmodule

/* dv/tb_jump_mat_contact_flight_timer_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench of jump_mat_contact_flight_timer_unit: drives timer ticks,
// predicts the result beats of every accepted tick and checks them in order.
// Depends on jmcf_pkg, jmcf_in_if, jmcf_out_if and the RTL of the block.
module tb_jump_mat_contact_flight_timer_unit;
    import jmcf_pkg::*;

    localparam int TW             = TIME_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 300;
    // Settling cycles after the drain make sure a tick without results has settled
    // before a register changes.
    localparam int SETTLE_CYCLES  = 4;

    // Phases of a test as the timer sees it.
    typedef enum logic [2:0] {WAIT_FIRST, ON_MAT, AIRBORNE, RESTING, ENDED} t_mat_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    jmcf_in_if  tick_ch ();
    jmcf_out_if report_ch ();

    jump_mat_contact_flight_timer_unit #(
        .TIME_BITS (TW)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_beat     (tick_ch),
        .o_result   (report_ch)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the registers and of the timing state, kept in step with every
    // accepted tick beat.
    t_cfg            timer_cfg;
    t_mat_phase      mat_phase;
    logic [TW-1:0]   tick_now;
    logic [TW-1:0]   ref_time;
    logic [TW-1:0]   contact_len;
    logic [SER_CNT_W-1:0]  jumps_in_ser;
    logic [SER_CNT_W-1:0]  series_cnt;
    logic [JUMP_CNT_W-1:0] jump_cnt;
    logic            lamp_on;

    // Result beats still owed by the block, oldest first.
    t_result         jump_reports_q[$];

    int              err_cnt = 0;
    int              ticks_sent = 0;
    int              idle_cycles = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    logic            holdoff_on = 1'b0;
    event            holdoff_ev;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void load_reg_defaults();
        timer_cfg.flight_min       = 16'd0;
        timer_cfg.flight_max       = 16'hFFFF;
        timer_cfg.cycle_max        = 24'hFFFFFF;
        timer_cfg.jumps_per_series = 8'd1;
        timer_cfg.series_total     = 8'd1;
        timer_cfg.rest_ticks       = 24'd0;
        timer_cfg.start_on_mat     = 1'b0;
    endfunction

    // A start bit and reset both bring the test back to waiting for first contact.
    function automatic void clear_timer_state();
        mat_phase    = WAIT_FIRST;
        tick_now     = '0;
        ref_time     = '0;
        contact_len  = '0;
        jumps_in_ser = '0;
        series_cnt   = '0;
        jump_cnt     = '0;
        lamp_on      = 1'b1;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FLIGHT_MIN:   timer_cfg.flight_min       = data[15:0];
            CFG_FLIGHT_MAX:   timer_cfg.flight_max       = data[15:0];
            CFG_CYCLE_MAX:    timer_cfg.cycle_max        = data[23:0];
            CFG_JUMPS_SERIES: timer_cfg.jumps_per_series = data[SER_CNT_W-1:0];
            CFG_SERIES_TOTAL: timer_cfg.series_total     = data[SER_CNT_W-1:0];
            CFG_REST_TICKS:   timer_cfg.rest_ticks       = data[23:0];
            CFG_START_ON_MAT: timer_cfg.start_on_mat     = data[0];
            default: ;
        endcase
    endfunction

    // Counters and the lamp are captured as they stand when the event is reported.
    function automatic void queue_report(logic [KIND_W-1:0] kind, logic [TW-1:0] flight,
                                         logic [TW-1:0] contact, logic cause);
        t_result r;
        r.kind          = kind;
        r.flight_ticks  = flight[OUT_TIME_W-1:0];
        r.contact_ticks = contact[OUT_TIME_W-1:0];
        r.jump_number   = jump_cnt;
        r.series_number = series_cnt;
        r.end_cause     = cause;
        r.ready_lamp    = lamp_on;
        r.last          = 1'b0;
        jump_reports_q.push_back(r);
    endfunction

    // Works out the result beats of one tick and queues them.
    function automatic void predict_tick(logic mat, logic stop, logic start);
        logic [TW-1:0] now_t;
        logic [TW-1:0] flight;
        logic [TW-1:0] since;
        logic [TW:0]   cyc;
        int            n_before;
        if (start) begin
            clear_timer_state();
        end
        now_t    = tick_now;
        n_before = jump_reports_q.size();
        case (mat_phase)
            WAIT_FIRST: begin
                if (mat) begin
                    ref_time  = timer_cfg.start_on_mat ? '0 : now_t;
                    mat_phase = ON_MAT;
                end
            end
            ON_MAT: begin
                if (!mat) begin
                    contact_len = now_t - ref_time;
                    ref_time    = now_t;
                    mat_phase   = AIRBORNE;
                end
            end
            AIRBORNE: begin
                if (mat) begin
                    flight    = now_t - ref_time;
                    ref_time  = now_t;
                    mat_phase = ON_MAT;
                    cyc       = flight + contact_len;
                    // Judging order: too short, too long, cycle too long, else valid.
                    if (flight < timer_cfg.flight_min) begin
                        queue_report(KIND_TOO_SHORT, flight, contact_len, 1'b0);
                    end else if (flight > timer_cfg.flight_max) begin
                        queue_report(KIND_TOO_LONG, flight, contact_len, 1'b0);
                    end else if (cyc > timer_cfg.cycle_max) begin
                        queue_report(KIND_CYCLE_LONG, flight, contact_len, 1'b0);
                    end else begin
                        jump_cnt     = jump_cnt + 1'b1;
                        jumps_in_ser = jumps_in_ser + 1'b1;
                        // A series is complete at or above the setting, so zero
                        // makes every valid jump a series of its own.
                        if (jumps_in_ser >= timer_cfg.jumps_per_series) begin
                            series_cnt = series_cnt + 1'b1;
                            mat_phase  = RESTING;
                            lamp_on    = 1'b0;
                        end
                        queue_report(KIND_VALID, flight, contact_len, 1'b0);
                    end
                end
            end
            RESTING: begin
                // The rest is timed from the last landing, which also stays the
                // reference for the next contact.
                since = now_t - ref_time;
                if (since >= timer_cfg.rest_ticks) begin
                    lamp_on      = 1'b1;
                    jumps_in_ser = '0;
                    mat_phase    = ON_MAT;
                    queue_report(KIND_REST_OVER, '0, '0, 1'b0);
                end
            end
            default: ;
        endcase
        // The end of the test follows any jump report of the same tick.
        if (mat_phase != ENDED) begin
            if (stop) begin
                mat_phase = ENDED;
                lamp_on   = 1'b1;
                queue_report(KIND_END, '0, '0, 1'b0);
            end else if (series_cnt >= timer_cfg.series_total) begin
                mat_phase = ENDED;
                lamp_on   = 1'b1;
                queue_report(KIND_END, '0, '0, 1'b1);
            end
        end
        if (jump_reports_q.size() > n_before) begin
            jump_reports_q[jump_reports_q.size()-1].last = 1'b1;
        end
        tick_now = tick_now + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checking, receiver and watchdog
    // ------------------------------------------------------------------

    function automatic int field_differs(string what, longint unsigned want,
                                         longint unsigned got);
        if (want == got) begin
            return 0;
        end
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        return 1;
    endfunction

    // Each accepted result beat is held against the oldest owed report.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && report_ch.valid && report_ch.ready) begin
            if (jump_reports_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual kind %0d",
                         $time, report_ch.kind);
                err_cnt++;
            end else begin
                want = jump_reports_q.pop_front();
                err_cnt += field_differs("kind", want.kind, report_ch.kind);
                err_cnt += field_differs("flight_ticks", want.flight_ticks,
                                         report_ch.flight_ticks);
                err_cnt += field_differs("contact_ticks", want.contact_ticks,
                                         report_ch.contact_ticks);
                err_cnt += field_differs("jump_number", want.jump_number,
                                         report_ch.jump_number);
                err_cnt += field_differs("series_number", want.series_number,
                                         report_ch.series_number);
                err_cnt += field_differs("end_cause", want.end_cause, report_ch.end_cause);
                err_cnt += field_differs("ready_lamp", want.ready_lamp, report_ch.ready_lamp);
                err_cnt += field_differs("last", want.last, report_ch.last);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one has been requested.
    always @(negedge i_clk) begin
        if (holdoff_on) begin
            report_ch.ready <= 1'b0;
        end else begin
            report_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The hold-off counts its own cycles so that the sender keeps offering ticks
    // meanwhile and the result queue fills up.
    always begin
        @(holdoff_ev);
        holdoff_on = 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge i_clk);
        holdoff_on = 1'b0;
    end

    // Ends a run in which neither channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) ||
            (report_ch.valid && report_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("jump_mat_contact_flight_timer_unit test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one tick beat after a random gap and predicts it once accepted.
    task automatic send_tick(input logic mat, input logic stop, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            tick_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        tick_ch.valid      <= 1'b1;
        tick_ch.on_mat     <= mat;
        tick_ch.stop_key   <= stop;
        tick_ch.start_test <= start;
        do @(posedge i_clk); while (!tick_ch.ready);
        predict_tick(mat, stop, start);
        ticks_sent++;
    endtask

    task automatic stay(input logic mat, input int n);
        repeat (n) send_tick(mat, 1'b0, 1'b0);
    endtask

    // Starting on the mat with contact begun at the previous tick: leaves after
    // the given contact, lands after the given flight. The landing tick begins
    // the next contact.
    task automatic do_jump(input int contact, input int flight);
        stay(1'b1, contact - 1);
        stay(1'b0, flight);
        stay(1'b1, 1);
    endtask

    task automatic begin_test(input logic mat);
        send_tick(mat, 1'b0, 1'b1);
    endtask

    // Stops offering ticks and waits until every owed result has come.
    task automatic wait_drained(input int extra);
        @(negedge i_clk);
        tick_ch.valid <= 1'b0;
        while (jump_reports_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        apply_reg(idx, data);
    endtask

    // Registers change only once the block has nothing left in flight.
    task automatic set_config(input int unsigned fmin, input int unsigned fmax,
                              input int unsigned cmax, input int unsigned jps,
                              input int unsigned stot, input int unsigned rest,
                              input bit som);
        wait_drained(SETTLE_CYCLES);
        write_reg(CFG_FLIGHT_MIN, CFG_DATA_W'(fmin));
        write_reg(CFG_FLIGHT_MAX, CFG_DATA_W'(fmax));
        write_reg(CFG_CYCLE_MAX, CFG_DATA_W'(cmax));
        write_reg(CFG_JUMPS_SERIES, CFG_DATA_W'(jps));
        write_reg(CFG_SERIES_TOTAL, CFG_DATA_W'(stot));
        write_reg(CFG_REST_TICKS, CFG_DATA_W'(rest));
        write_reg(CFG_START_ON_MAT, CFG_DATA_W'(som));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With the reset defaults a single valid jump completes the whole test, so
    // its landing tick yields the jump and the end; later ticks are ignored.
    task automatic test_reset_defaults();
        stay(1'b1, 1);
        stay(1'b0, 1);
        stay(1'b1, 1);
        send_tick(1'b1, 1'b1, 1'b0);
    endtask

    // Flights judged too short, too long, cycle too long and valid, with the
    // first contact timed from the start of the test.
    task automatic test_judging_order();
        set_config(2, 4, 6, 255, 255, 0, 1'b1);
        begin_test(1'b0);
        stay(1'b0, 1);
        stay(1'b1, 1);
        do_jump(1, 1);
        do_jump(1, 5);
        do_jump(4, 3);
        do_jump(3, 3);
        do_jump(1, 2);
        send_tick(1'b1, 1'b1, 1'b0);
    endtask

    // Two series of two jumps with a rest in between; contact after the rest
    // still counts from the last landing, and the final jump ends the test.
    task automatic test_series_and_rest();
        set_config(0, 65535, 16777215, 2, 2, 3, 1'b0);
        begin_test(1'b0);
        stay(1'b0, 2);
        stay(1'b1, 1);
        do_jump(2, 1);
        do_jump(1, 1);
        stay(1'b0, 4);
        stay(1'b1, 1);
        do_jump(1, 1);
        send_tick(1'b0, 1'b0, 1'b0);
    endtask

    // Zero settings: no series needed ends the test at once, a zero series
    // length makes every valid jump a series, and a zero rest ends at once.
    task automatic test_zero_settings();
        set_config(0, 0, 0, 1, 0, 0, 1'b1);
        begin_test(1'b1);
        set_config(0, 65535, 16777215, 0, 3, 0, 1'b0);
        begin_test(1'b1);
        do_jump(1, 1);
        stay(1'b1, 1);
        do_jump(1, 1);
        send_tick(1'b0, 1'b1, 1'b0);
    endtask

    // The receiver holds off while short valid jumps keep arriving, so the
    // result queue fills and the tick input stalls.
    task automatic test_backpressure();
        set_config(0, 65535, 16777215, 255, 255, 0, 1'b0);
        begin_test(1'b1);
        -> holdoff_ev;
        repeat (40) do_jump(1, 1);
        wait_drained(SETTLE_CYCLES);
    endtask

    // One test with random settings: mostly whole jumps whose flights straddle
    // the limits, some noise ticks, stray stops and restarts.
    task automatic run_random_episode();
        int unsigned fmin;
        int unsigned fmax;
        int unsigned cmax;
        int unsigned jps;
        int unsigned stot;
        int unsigned rest;
        int unsigned lim;
        int unsigned sel;
        int          n_moves;
        sel  = $urandom_range(19);
        fmin = (sel == 0) ? 65535 : $urandom_range(5);
        sel  = $urandom_range(19);
        fmax = (sel == 0) ? 0 : (sel == 1 || fmin > 100) ? 65535 : fmin + $urandom_range(8);
        sel  = $urandom_range(19);
        cmax = (sel == 0) ? 0 : (sel == 1) ? 16777215 : $urandom_range(24, 2);
        sel  = $urandom_range(19);
        jps  = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(4, 1);
        sel  = $urandom_range(19);
        stot = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(4, 1);
        sel  = $urandom_range(19);
        rest = (sel == 0) ? 16777215 : $urandom_range(5);
        set_config(fmin, fmax, cmax, jps, stot, rest, 1'($urandom_range(1)));
        lim = (fmax < 20) ? fmax + 3 : 12;
        begin_test(1'($urandom_range(1)));
        n_moves = $urandom_range(20, 6);
        repeat (n_moves) begin
            sel = $urandom_range(99);
            if (sel < 80) begin
                do_jump($urandom_range(6, 1), $urandom_range(lim, 1));
            end else if (sel < 90) begin
                send_tick(1'($urandom_range(1)), $urandom_range(15) == 0,
                          $urandom_range(15) == 0);
            end else if (sel < 95) begin
                stay(1'($urandom_range(1)), $urandom_range(6, 1));
            end else if (sel < 98) begin
                send_tick(1'($urandom_range(1)), 1'b1, 1'b0);
            end else begin
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
            end
        end
    endtask

    task automatic test_random(input int n_ticks, input int send_pct, input int recv_pct);
        int first_tick;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first_tick     = ticks_sent;
        while (ticks_sent - first_tick < n_ticks) begin
            run_random_episode();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_FLIGHT_MIN;
        i_cfg_data           = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.on_mat       = 1'b0;
        tick_ch.stop_key     = 1'b0;
        tick_ch.start_test   = 1'b0;
        load_reg_defaults();
        clear_timer_state();
        send_idle_pct  = 8;
        recv_stall_pct = 66;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_judging_order();
        test_series_and_rest();
        test_zero_settings();
        test_random(230, 8, 66);
        test_backpressure();
        test_random(230, 66, 8);
        test_random(230, 0, 0);

        wait_drained(8);
        if (err_cnt == 0) begin
            $display("jump_mat_contact_flight_timer_unit test passed");
        end else begin
            $display("jump_mat_contact_flight_timer_unit test failed");
        end
        $finish;
    end

endmodule
